@@ rtl/core/lom_pkg.sv @@
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and codes of the limit order matcher: command and result
// items, status and kind codes, sequencer states.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int PORT_PRICE_W = 16;
    localparam int ID_W         = 32;
    localparam int QTY_W        = 32;
    localparam int TRADE_CNT_W  = 6;
    // trades per item, one result slot stays for the closing status
    localparam int MAX_TRADES   = 63;
    // arrival stamp, wide enough never to wrap in service
    localparam int STAMP_W      = 64;

    typedef logic [PORT_PRICE_W-1:0] t_price;
    typedef logic [ID_W-1:0]         t_id;
    typedef logic [QTY_W-1:0]        t_qty;
    typedef logic [STAMP_W-1:0]      t_stamp;

    localparam logic FUNC_CLEAR = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;
    localparam logic SIDE_SELL  = 1'b1;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_RESTING  = 2'd0;
    localparam logic [1:0] STATUS_FILLED   = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;
    localparam logic [1:0] STATUS_CLEARED  = 2'd3;

    // classified command between front end and matching engine
    typedef struct packed {
        logic   clear;
        t_id    ord_num;
        logic   side;
        t_price price;
        t_qty   quantity;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        t_id        buy_id;
        t_id        sell_id;
        t_price     trade_price;
        t_qty       trade_qty;
        logic [1:0] status;
        t_qty       remaining_qty;
        logic       last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FINAL
    } t_state;

endpackage

@@ rtl/core/lom_if.sv @@
// ----------------------------------------------------------------------------
// lom_in_if / lom_out_if
// Valid/ready channels of the order matcher: order items in, results out.
// ----------------------------------------------------------------------------
interface lom_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    lom_pkg::t_id        ord_num;
    logic                side;
    lom_pkg::t_price     price;
    lom_pkg::t_qty       quantity;

    modport source (output valid, func, ord_num, side, price, quantity, input ready);
    modport sink   (input valid, func, ord_num, side, price, quantity, output ready);
endinterface

interface lom_out_if;
    logic                valid;
    logic                ready;
    logic                kind;
    lom_pkg::t_id        buy_id;
    lom_pkg::t_id        sell_id;
    lom_pkg::t_price     trade_price;
    lom_pkg::t_qty       trade_qty;
    logic [1:0]          status;
    lom_pkg::t_qty       remaining_qty;
    logic                last;

    modport source (output valid, kind, buy_id, sell_id, trade_price, trade_qty, status,
                    remaining_qty, last, input ready);
    modport sink   (input valid, kind, buy_id, sell_id, trade_price, trade_qty, status,
                    remaining_qty, last, output ready);
endinterface

@@ rtl/core/lom_front.sv @@
// ----------------------------------------------------------------------------
// lom_front
// Input stage: registers each item, decodes the function and masks the
// price to the book's price width.
// ----------------------------------------------------------------------------
module lom_front #(
    parameter int PRICE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_func,
    input  lom_pkg::t_id    i_ord_num,
    input  logic            i_side,
    input  lom_pkg::t_price i_price,
    input  lom_pkg::t_qty   i_quantity,
    output logic            o_ready,
    output logic            o_cmd_valid,
    output lom_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_ready
);

    localparam int PW = (PRICE_BITS < lom_pkg::PORT_PRICE_W) ? PRICE_BITS
                                                            : lom_pkg::PORT_PRICE_W;
    localparam lom_pkg::t_price PMASK = (PW >= lom_pkg::PORT_PRICE_W) ? '1 :
        lom_pkg::t_price'((32'd1 << PW) - 32'd1);

    logic          r_valid;
    lom_pkg::t_cmd r_cmd;
    lom_pkg::t_cmd n_cmd;

    // take a new item whenever the stage is empty or drains this cycle
    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // classify the item
    always_comb begin
        n_cmd.clear    = (i_func == lom_pkg::FUNC_CLEAR);
        n_cmd.ord_num  = i_ord_num;
        n_cmd.side     = i_side;
        n_cmd.price    = i_price & PMASK;
        n_cmd.quantity = i_quantity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ rtl/core/lom_queue.sv @@
// ----------------------------------------------------------------------------
// lom_queue
// Two-entry command queue between the front end and the matching engine.
// ----------------------------------------------------------------------------
module lom_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lom_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output lom_pkg::t_cmd o_cmd,
    input  logic          i_ready
);

    lom_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/lom_back.sv @@
// ----------------------------------------------------------------------------
// lom_back
// Matching engine: slot pool, sequential best-price scan, fills, slot
// release, arrival stamps for time priority, and the result register.
// ----------------------------------------------------------------------------
module lom_back #(
    parameter int SLOT_COUNT = 64,
    parameter int PRICE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lom_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    output logic          o_res_valid,
    output lom_pkg::t_res o_res,
    input  logic          i_res_ready
);

    localparam int PW = (PRICE_BITS < lom_pkg::PORT_PRICE_W) ? PRICE_BITS
                                                            : lom_pkg::PORT_PRICE_W;
    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [lom_pkg::TRADE_CNT_W-1:0] TRADE_LIM =
        lom_pkg::TRADE_CNT_W'(lom_pkg::MAX_TRADES);

    // slot memories
    logic            mem_side  [SLOT_COUNT];
    logic [PW-1:0]   mem_price [SLOT_COUNT];
    lom_pkg::t_id    mem_id    [SLOT_COUNT];
    lom_pkg::t_qty   mem_qty   [SLOT_COUNT];
    lom_pkg::t_stamp mem_stamp [SLOT_COUNT];
    logic            rd_side;
    logic [PW-1:0]   rd_price;
    lom_pkg::t_id    rd_id;
    lom_pkg::t_qty   rd_qty;
    lom_pkg::t_stamp rd_stamp;

    // per-slot occupancy and the next arrival stamp
    logic [SLOT_COUNT-1:0] r_valid;
    lom_pkg::t_stamp       r_stamp;

    lom_pkg::t_state r_state;
    lom_pkg::t_state n_state;
    lom_pkg::t_cmd   r_cmd;
    lom_pkg::t_qty   r_qty;
    logic [IW-1:0]   r_slot;
    logic            r_first;
    logic [lom_pkg::TRADE_CNT_W-1:0] r_n;

    // scan pipeline
    logic [IW-1:0]   r_addr;
    logic            r_issue;
    logic            r_pv;
    logic [IW-1:0]   r_pidx;
    logic            r_ffound;
    logic [IW-1:0]   r_fidx;
    logic            r_bfound;
    logic [IW-1:0]   r_bidx;
    logic [PW-1:0]   r_bprice;
    lom_pkg::t_qty   r_bqty;
    lom_pkg::t_id    r_bid;
    lom_pkg::t_stamp r_bstamp;

    // pending status and result register
    logic [1:0]      r_fin_status;
    lom_pkg::t_qty   r_fin_rem;
    logic            r_out_valid;
    lom_pkg::t_res   r_out;

    logic            cur_valid;
    logic            cur_opp;
    logic            better_px;
    logic            take_best;
    logic            take_free;
    logic            scan_end;
    logic [PW-1:0]   cmd_px;
    logic            crosses;
    logic            match_go;
    lom_pkg::t_qty   fill_m;
    lom_pkg::t_qty   rest_left;
    logic            emit_ok;
    logic            fill_ok;

    logic            s_accept;
    logic            s_start_scan;
    logic            s_insert;
    logic            s_fill;
    logic            s_emit_trade;
    logic            s_emit_final;
    logic            s_release;
    logic [IW-1:0]   s_rel_idx;
    logic            s_qty_we;
    logic [IW-1:0]   s_qty_wa;
    lom_pkg::t_qty   s_qty_wd;
    logic            s_fin_load;
    logic [1:0]      s_fin_status;
    lom_pkg::t_qty   s_fin_rem;
    lom_pkg::t_res   s_res;

    // scan compare on the slot that was read last cycle
    always_comb begin
        cur_valid = r_valid[r_pidx];
        cur_opp   = r_pv && cur_valid && (rd_side != r_cmd.side);
        better_px = (r_cmd.side == lom_pkg::SIDE_BUY) ? (rd_price < r_bprice)
                                                      : (rd_price > r_bprice);
        take_best = cur_opp && (!r_bfound ||
                    ((rd_price == r_bprice) ? (rd_stamp < r_bstamp) : better_px));
        take_free = r_pv && !cur_valid && !r_ffound;
        scan_end  = r_pv && (r_pidx == LAST_IDX);
    end

    // fill decision against the best resting order
    always_comb begin
        cmd_px    = r_cmd.price[PW-1:0];
        crosses   = (r_cmd.side == lom_pkg::SIDE_BUY) ? !(cmd_px < r_bprice)
                                                      : !(cmd_px > r_bprice);
        match_go  = (r_qty != '0) && (r_n != TRADE_LIM) && r_bfound && crosses;
        fill_m    = (r_qty < r_bqty) ? r_qty : r_bqty;
        rest_left = r_bqty - fill_m;
        emit_ok   = !r_out_valid || i_res_ready;
        fill_ok   = (fill_m == '0) || emit_ok;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lom_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.clear ? lom_pkg::ST_FINAL : lom_pkg::ST_SCAN;
                end
            end
            lom_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = lom_pkg::ST_DECIDE;
                end
            end
            lom_pkg::ST_DECIDE: begin
                if (r_first) begin
                    n_state = r_ffound ? lom_pkg::ST_DECIDE : lom_pkg::ST_FINAL;
                end else if (match_go) begin
                    n_state = fill_ok ? lom_pkg::ST_SCAN : lom_pkg::ST_DECIDE;
                end else begin
                    n_state = lom_pkg::ST_FINAL;
                end
            end
            lom_pkg::ST_FINAL: begin
                if (emit_ok) begin
                    n_state = lom_pkg::ST_IDLE;
                end
            end
            default: n_state = lom_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_cmd_ready  = (r_state == lom_pkg::ST_IDLE);
        s_accept     = o_cmd_ready && i_cmd_valid;
        s_insert     = (r_state == lom_pkg::ST_DECIDE) && r_first && r_ffound;
        s_fill       = (r_state == lom_pkg::ST_DECIDE) && !r_first && match_go && fill_ok;
        s_emit_trade = s_fill && (fill_m != '0);
        s_emit_final = (r_state == lom_pkg::ST_FINAL) && emit_ok;
        s_start_scan = (s_accept && !i_cmd.clear) || s_fill;

        s_fin_load   = 1'b0;
        s_fin_status = lom_pkg::STATUS_RESTING;
        s_fin_rem    = r_qty;
        s_release    = 1'b0;
        s_rel_idx    = r_bidx;
        s_qty_we     = 1'b0;
        s_qty_wa     = r_fidx;
        s_qty_wd     = r_cmd.quantity;

        if (s_accept && i_cmd.clear) begin
            s_fin_load   = 1'b1;
            s_fin_status = lom_pkg::STATUS_CLEARED;
            s_fin_rem    = '0;
        end
        if ((r_state == lom_pkg::ST_DECIDE) && r_first && !r_ffound) begin
            s_fin_load   = 1'b1;
            s_fin_status = lom_pkg::STATUS_REJECTED;
            s_fin_rem    = r_cmd.quantity;
        end
        if (s_insert) begin
            s_qty_we = 1'b1;
        end
        if (s_fill) begin
            s_qty_we  = 1'b1;
            s_qty_wa  = r_bidx;
            s_qty_wd  = rest_left;
            s_release = (rest_left == '0);
        end
        if ((r_state == lom_pkg::ST_DECIDE) && !r_first && !match_go) begin
            s_fin_load   = 1'b1;
            s_fin_status = (r_qty == '0) ? lom_pkg::STATUS_FILLED : lom_pkg::STATUS_RESTING;
            s_fin_rem    = r_qty;
            s_rel_idx    = r_slot;
            s_release    = (r_qty == '0);
            s_qty_we     = (r_qty != '0);
            s_qty_wa     = r_slot;
            s_qty_wd     = r_qty;
        end

        // result item: trade while filling, else the closing status
        s_res = '0;
        if (s_emit_trade) begin
            s_res.kind        = lom_pkg::KIND_TRADE;
            s_res.buy_id      = (r_cmd.side == lom_pkg::SIDE_BUY) ? r_cmd.ord_num : r_bid;
            s_res.sell_id     = (r_cmd.side == lom_pkg::SIDE_BUY) ? r_bid : r_cmd.ord_num;
            s_res.trade_price = lom_pkg::t_price'(r_bprice);
            s_res.trade_qty   = fill_m;
        end else begin
            s_res.kind          = lom_pkg::KIND_STATUS;
            s_res.status        = r_fin_status;
            s_res.remaining_qty = r_fin_rem;
            s_res.last          = 1'b1;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lom_pkg::ST_IDLE;
            r_issue     <= 1'b0;
            r_pv        <= 1'b0;
            r_first     <= 1'b0;
            r_ffound    <= 1'b0;
            r_bfound    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == lom_pkg::ST_SCAN) && r_issue;
            if (s_accept) begin
                r_first <= 1'b1;
            end else if (s_insert) begin
                r_first <= 1'b0;
            end
            if (s_start_scan) begin
                r_issue  <= 1'b1;
                r_ffound <= 1'b0;
                r_bfound <= 1'b0;
            end else begin
                if ((r_state == lom_pkg::ST_SCAN) && r_issue && (r_addr == LAST_IDX)) begin
                    r_issue <= 1'b0;
                end
                if (take_free) begin
                    r_ffound <= 1'b1;
                end
                if (take_best) begin
                    r_bfound <= 1'b1;
                end
            end
            if (s_emit_trade || s_emit_final) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // occupancy: clear, insert, release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (s_accept && i_cmd.clear) begin
            r_valid <= '0;
        end else if (s_insert) begin
            r_valid[r_fidx] <= 1'b1;
        end else if (s_release) begin
            r_valid[s_rel_idx] <= 1'b0;
        end
    end

    // arrival stamp: advance on every insert, a lower stamp is older
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else if (s_insert) begin
            r_stamp <= r_stamp + 1'b1;
        end
    end

    // working registers of the current item
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_cmd;
            r_qty <= i_cmd.quantity;
            r_n   <= '0;
        end
        if (s_fill) begin
            r_qty <= r_qty - fill_m;
        end
        if (s_emit_trade) begin
            r_n <= r_n + 1'b1;
        end
        if (s_insert) begin
            r_slot <= r_fidx;
        end
        if (s_fin_load) begin
            r_fin_status <= s_fin_status;
            r_fin_rem    <= s_fin_rem;
        end
        if (s_emit_trade || s_emit_final) begin
            r_out <= s_res;
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr;
        if (s_start_scan) begin
            r_addr <= '0;
        end else begin
            if ((r_state == lom_pkg::ST_SCAN) && r_issue && (r_addr != LAST_IDX)) begin
                r_addr <= r_addr + 1'b1;
            end
            if (take_free) begin
                r_fidx <= r_pidx;
            end
            if (take_best) begin
                r_bidx   <= r_pidx;
                r_bprice <= rd_price;
                r_bqty   <= rd_qty;
                r_bid    <= rd_id;
                r_bstamp <= rd_stamp;
            end
        end
    end

    // slot memories: one write per field, registered read at the scan address
    always_ff @(posedge i_clk) begin
        if (s_insert) begin
            mem_side[r_fidx]  <= r_cmd.side;
            mem_price[r_fidx] <= cmd_px;
            mem_id[r_fidx]    <= r_cmd.ord_num;
            mem_stamp[r_fidx] <= r_stamp;
        end
        if (s_qty_we) begin
            mem_qty[s_qty_wa] <= s_qty_wd;
        end
        rd_side  <= mem_side[r_addr];
        rd_price <= mem_price[r_addr];
        rd_id    <= mem_id[r_addr];
        rd_qty   <= mem_qty[r_addr];
        rd_stamp <= mem_stamp[r_addr];
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ rtl/core/limit_order_matcher_top.sv @@
// ----------------------------------------------------------------------------
// limit_order_matcher_top
// Price-time priority limit order book over a fixed pool of order slots.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per order (func, ord_num, side, price, quantity)
//   or a clear command; o_out returns zero or more trade items followed by
//   one status item with last set.
//   Each item is registered, queued (two deep) and then run by the matching
//   engine, one item at a time. A pass over the pool reads one slot per
//   cycle; the first pass finds a free slot and the best opposite order,
//   and every fill starts a new pass.
//   Reset empties the book at once; no clearing pass is needed.
//   When o_out stalls, the engine holds before each result and the input
//   side keeps accepting until the front stage and the queue are full.
// ----------------------------------------------------------------------------
module limit_order_matcher_top #(
    parameter int SLOT_COUNT = 64,
    parameter int PRICE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lom_in_if.sink    i_in,
    lom_out_if.source o_out
);

    logic          f_valid;
    logic          f_ready;
    lom_pkg::t_cmd f_cmd;
    logic          q_valid;
    logic          q_ready;
    lom_pkg::t_cmd q_cmd;
    logic          res_valid;
    lom_pkg::t_res res;

    lom_front #(.PRICE_BITS(PRICE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_func      (i_in.func),
        .i_ord_num   (i_in.ord_num),
        .i_side      (i_in.side),
        .i_price     (i_in.price),
        .i_quantity  (i_in.quantity),
        .o_ready     (i_in.ready),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    lom_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_cmd   (f_cmd),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_ready (q_ready)
    );

    lom_back #(.SLOT_COUNT(SLOT_COUNT), .PRICE_BITS(PRICE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_out.ready)
    );

    // drive the result channel
    assign o_out.valid         = res_valid;
    assign o_out.kind          = res.kind;
    assign o_out.buy_id        = res.buy_id;
    assign o_out.sell_id       = res.sell_id;
    assign o_out.trade_price   = res.trade_price;
    assign o_out.trade_qty     = res.trade_qty;
    assign o_out.status        = res.status;
    assign o_out.remaining_qty = res.remaining_qty;
    assign o_out.last          = res.last;

    // front stage holds its command until the queue takes it
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_cmd))
        else $error("front stage dropped or changed a stalled command");

    // queue head holds while the engine is busy
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_cmd))
        else $error("queue head dropped or changed while engine busy");

    // a trade item never closes an input and carries no status
    a_trade_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind == lom_pkg::KIND_TRADE) |->
            !o_out.last && (o_out.status == lom_pkg::STATUS_RESTING) &&
            (o_out.trade_qty != '0))
        else $error("malformed trade item");

    // a status item always closes its input
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind == lom_pkg::KIND_STATUS) |-> o_out.last)
        else $error("status item without last");

endmodule
